// ===== hdl/pipr_pkg.sv =====
`default_nettype none
package pipr_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_loc;

    localparam t_cmd CMD_APPEND = 2'd0;
    localparam t_cmd CMD_CLEAR  = 2'd1;
    localparam t_cmd CMD_LOCATE = 2'd2;

    localparam t_loc LOC_OUTSIDE = 2'd0;
    localparam t_loc LOC_INSIDE  = 2'd1;
    localparam t_loc LOC_ON_EDGE = 2'd2;

    localparam int OUT_BITS = 3;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    typedef struct packed {
        logic valid;
        logic hit;
        logic toggle;
    } t_edge_res;

endpackage
`default_nettype wire

// ===== hdl/pipr_cell.sv =====
`default_nettype none
module pipr_cell #(
    parameter int COORD_BITS = 16
) (
    input  wire                          i_clk,
    input  pipr_pkg::t_cell_ctrl         i_ctrl,
    input  wire signed [COORD_BITS-1:0]  i_ld_x,
    input  wire signed [COORD_BITS-1:0]  i_ld_y,
    input  wire signed [COORD_BITS-1:0]  i_nb_x,
    input  wire signed [COORD_BITS-1:0]  i_nb_y,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y
);
    import pipr_pkg::*;

    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_ld_x;
            r_y <= i_ld_y;
        end else if (i_ctrl.shift) begin
            r_x <= i_nb_x;
            r_y <= i_nb_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule
`default_nettype wire

// ===== hdl/pipr_edge.sv =====
`default_nettype none
module pipr_edge #(
    parameter int COORD_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    input  wire signed [COORD_BITS-1:0] i_px,
    input  wire signed [COORD_BITS-1:0] i_py,
    input  wire signed [COORD_BITS-1:0] i_x1,
    input  wire signed [COORD_BITS-1:0] i_y1,
    input  wire signed [COORD_BITS-1:0] i_x2,
    input  wire signed [COORD_BITS-1:0] i_y2,
    output pipr_pkg::t_edge_res         o_res
);
    import pipr_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic signed [DW-1:0] w_ax;
    logic signed [DW-1:0] w_ay;
    logic                 w_vhit;
    logic                 w_horiz;
    logic                 w_xbet;
    logic                 w_ybet;
    logic                 w_cross_y;

    logic                 r_a_valid;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic signed [DW-1:0] r_ax;
    logic signed [DW-1:0] r_ay;
    logic                 r_a_hit;
    logic                 r_a_horiz;
    logic                 r_a_ybet;
    logic                 r_a_cross_y;
    logic                 r_a_dypos;

    logic                 r_b_valid;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic                 r_b_hit;
    logic                 r_b_horiz;
    logic                 r_b_ybet;
    logic                 r_b_cross_y;
    logic                 r_b_dypos;

    logic [PW:0]          w_cross;
    logic                 w_zero;
    logic                 w_pos;

    always_comb begin
        w_dx      = {i_x2[COORD_BITS-1], i_x2} - {i_x1[COORD_BITS-1], i_x1};
        w_dy      = {i_y2[COORD_BITS-1], i_y2} - {i_y1[COORD_BITS-1], i_y1};
        w_ax      = {i_px[COORD_BITS-1], i_px} - {i_x1[COORD_BITS-1], i_x1};
        w_ay      = {i_py[COORD_BITS-1], i_py} - {i_y1[COORD_BITS-1], i_y1};
        w_vhit    = (i_px == i_x1) && (i_py == i_y1);
        w_horiz   = (i_y1 == i_y2);
        w_xbet    = ((i_px >= i_x1) && (i_px <= i_x2)) || ((i_px >= i_x2) && (i_px <= i_x1));
        w_ybet    = ((i_py >= i_y1) && (i_py <= i_y2)) || ((i_py >= i_y2) && (i_py <= i_y1));
        w_cross_y = (i_y1 > i_py) != (i_y2 > i_py);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
        r_dx        <= w_dx;
        r_dy        <= w_dy;
        r_ax        <= w_ax;
        r_ay        <= w_ay;
        r_a_hit     <= w_vhit || (w_horiz && (i_py == i_y1) && w_xbet);
        r_a_horiz   <= w_horiz;
        r_a_ybet    <= w_ybet;
        r_a_cross_y <= w_cross_y;
        r_a_dypos   <= !w_horiz && !w_dy[DW-1];

        r_p1        <= r_dx * r_ay;
        r_p2        <= r_dy * r_ax;
        r_b_hit     <= r_a_hit;
        r_b_horiz   <= r_a_horiz;
        r_b_ybet    <= r_a_ybet;
        r_b_cross_y <= r_a_cross_y;
        r_b_dypos   <= r_a_dypos;
    end

    always_comb begin
        w_cross      = {r_p1[PW-1], r_p1} - {r_p2[PW-1], r_p2};
        w_zero       = (w_cross == '0);
        w_pos        = !w_cross[PW] && !w_zero;
        o_res.valid  = r_b_valid;
        o_res.hit    = r_b_valid && (r_b_hit || (!r_b_horiz && w_zero && r_b_ybet));
        o_res.toggle = r_b_valid && !r_b_horiz && !w_zero && r_b_cross_y
                       && (w_pos == r_b_dypos);
    end

endmodule
`default_nettype wire

// ===== hdl/point_in_polygon_ray_cast.sv =====
// Append, clear and unused commands stay in S_IDLE; next transaction the cycle after.
// Locate: the vertex ring rotates once past the edge unit, one vertex per cycle,
// then the edge pipeline drains in S_DRAIN and the result is offered from S_DONE.
// No input is taken until the result is loaded and the FSM returns to S_IDLE.
// Synchronous active-low reset clears the vertex count, the overflow flag, the FSM
// and the output valid; vertex cells are not reset and hold nothing until written.
`default_nettype none
module point_in_polygon_ray_cast #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16,
    localparam int IN_W        = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [IN_W-1:0]              s_axis_tdata,   // coord_x, coord_y
    input  wire  [1:0]                   s_axis_tuser,   // command
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [pipr_pkg::OUT_W-1:0]   m_axis_tdata    // location, vertices_dropped
);
    import pipr_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(MAX_VERTICES);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_step;
    logic                    r_drain;
    logic                    r_overflow;
    logic                    r_parity;
    logic                    r_onedge;
    logic                    r_out_valid;
    t_loc                    r_out_loc;
    logic                    r_out_drop;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y;

    logic signed [COORD_BITS-1:0] w_cx [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] w_cy [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] w_in_x, w_in_y;
    logic signed [COORD_BITS-1:0] w_x2, w_y2;
    t_cmd                    w_cmd;
    logic                    w_accept;
    logic                    w_append;
    logic                    w_shift;
    logic                    w_edge_valid;
    logic                    w_closing;
    logic                    n_out_load;
    t_edge_res               w_res;

    assign w_cmd    = s_axis_tuser;
    assign w_in_x   = s_axis_tdata[COORD_BITS-1:0];
    assign w_in_y   = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_append = w_accept && (w_cmd == CMD_APPEND) && (r_count < LAST_STEP);
    assign w_shift  = (r_state == S_SCAN) && (r_step != LAST_STEP);
    assign s_axis_tready = (r_state == S_IDLE);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
            t_cell_ctrl w_ctrl;
            assign w_ctrl.shift = w_shift;
            assign w_ctrl.load  = w_append && (r_count[IW-1:0] == IW'(gi));
            pipr_cell #(.COORD_BITS(COORD_BITS)) u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl),
                .i_ld_x (w_in_x),
                .i_ld_y (w_in_y),
                .i_nb_x (w_cx[(gi + 1) % MAX_VERTICES]),
                .i_nb_y (w_cy[(gi + 1) % MAX_VERTICES]),
                .o_x    (w_cx[gi]),
                .o_y    (w_cy[gi])
            );
        end
    endgenerate

    assign w_closing    = (r_step == r_count);
    assign w_edge_valid = (r_state == S_SCAN) && (r_step != '0) && (r_step <= r_count);
    assign w_x2         = w_closing ? r_first_x : w_cx[0];
    assign w_y2         = w_closing ? r_first_y : w_cy[0];

    pipr_edge #(.COORD_BITS(COORD_BITS)) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_edge_valid),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_x1    (r_prev_x),
        .i_y1    (r_prev_y),
        .i_x2    (w_x2),
        .i_y2    (w_y2),
        .o_res   (w_res)
    );

    assign n_out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_step      <= '0;
            r_drain     <= 1'b0;
            r_parity    <= 1'b0;
            r_onedge    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_res.valid) begin
                r_parity <= r_parity ^ w_res.toggle;
                r_onedge <= r_onedge | w_res.hit;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_cmd)
                            CMD_APPEND: begin
                                if (r_count < LAST_STEP) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_overflow <= 1'b1;
                                end
                            end
                            CMD_CLEAR: begin
                                r_count    <= '0;
                                r_overflow <= 1'b0;
                            end
                            CMD_LOCATE: begin
                                r_step   <= '0;
                                r_parity <= 1'b0;
                                r_onedge <= 1'b0;
                                r_state  <= S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_step == LAST_STEP) begin
                        r_drain <= 1'b0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_drain <= 1'b1;
                    if (r_drain) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px <= w_in_x;
            r_py <= w_in_y;
        end
        if (r_state == S_SCAN) begin
            r_prev_x <= w_cx[0];
            r_prev_y <= w_cy[0];
            if (r_step == '0) begin
                r_first_x <= w_cx[0];
                r_first_y <= w_cy[0];
            end
        end
        if (n_out_load) begin
            r_out_drop <= r_overflow;
            if (r_onedge || (w_res.valid && w_res.hit)) begin
                r_out_loc <= LOC_ON_EDGE;
            end else if (r_parity) begin
                r_out_loc <= LOC_INSIDE;
            end else begin
                r_out_loc <= LOC_OUTSIDE;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, r_out_drop, r_out_loc};

endmodule
`default_nettype wire

// ===== hdl/pipr_chk.sv =====
`default_nettype none
module pipr_chk (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        s_axis_tvalid,
    input wire                        s_axis_tready,
    input wire [1:0]                  s_axis_tuser,
    input wire                        m_axis_tvalid,
    input wire                        m_axis_tready,
    input wire [pipr_pkg::OUT_W-1:0]  m_axis_tdata
);
    import pipr_pkg::*;

    logic w_in_acc;
    logic w_locate;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_locate = w_in_acc && (s_axis_tuser == CMD_LOCATE);

    a_busy_after_locate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_locate |=> !s_axis_tready)
        else $error("input taken right after a locate transaction");

    a_ready_after_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_locate) |=> s_axis_tready)
        else $error("not ready after a non-locate transaction");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_locate |=> !$rose(m_axis_tvalid))
        else $error("result offered one cycle after locate");

    a_loc_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("invalid location code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output transaction changed");

endmodule

bind point_in_polygon_ray_cast pipr_chk u_pipr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
